FILE: design/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define CHK_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHK_RST(lbl, clk, rstn, prop, msg)
`define CHK_ALL(lbl, clk, prop, msg)
`endif
`endif

FILE: design/mexp_pkg.sv
// Shared types and constants for the modular exponentiation core.
`timescale 1ns / 1ps
package mexp_pkg;
    localparam int EXP_BITS_DEF = 32;
    localparam int MOD_BITS_DEF = 31;
    localparam int MUL_W        = 32;   // multiplier operand width (base port width)
    localparam logic [31:0] MOD_RESET = 32'd1000000007;

    typedef enum logic {
        TAG_ACC = 1'b0,
        TAG_BAS = 1'b1
    } t_tag;

    typedef struct packed {
        logic valid;
        t_tag tag;
    } t_ctl;
endpackage

FILE: design/modular_exponentiation_core.sv
// Modular exponentiation core: right-to-left square-and-multiply over a cell chain.
// Each exponent bit is one trip through the 32-cell multiplier chain, with a multiply for a
// set bit issued ahead of the square. The next item is accepted the cycle after the result
// is registered; a finished result may wait in the output register while the next item runs.
// Synchronous active-low reset; the modulus register resets to 1000000007.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module modular_exponentiation_core #(
    parameter int EXP_BITS = mexp_pkg::EXP_BITS_DEF,
    parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [MOD_BITS-1:0] i_cfg_modulus,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [31:0]         i_base_value,
    input  logic [31:0]         i_exponent,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [30:0]         o_power_result
);
    localparam int MW = mexp_pkg::MUL_W;
    localparam int CW = $clog2(EXP_BITS + 1);
    localparam logic [CW-1:0] LAST = CW'(EXP_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_RED_ISSUE, S_RED_WAIT, S_ISSUE, S_WAIT, S_FIN
    } t_state;

    t_state                r_state;
    logic [MOD_BITS-1:0]   r_mod, r_acc, r_b;
    logic [31:0]           r_base_in;
    logic [EXP_BITS-1:0]   r_exp;
    logic [CW-1:0]         r_cnt;
    logic                  r_mul_sent;
    logic                  r_out_valid;
    logic [30:0]           r_out;
    logic [EXP_BITS+31:0]  exp_ext;

    // chain taps
    mexp_pkg::t_ctl        c_ctl  [MW+1];
    logic [MOD_BITS-1:0]   c_r    [MW+1];
    logic [MOD_BITS-1:0]   c_a    [MW+1];
    logic [MOD_BITS-1:0]   c_m    [MW+1];
    logic [MW-1:0]         c_mult [MW+1];
    logic [MW-1:0]         b_ext;

    assign exp_ext = {{EXP_BITS{1'b0}}, i_exponent};
    assign b_ext   = {{(MW-MOD_BITS){1'b0}}, r_b};

    always_comb begin
        c_ctl[0]  = '0;
        c_r[0]    = '0;
        c_m[0]    = r_mod;
        c_a[0]    = r_b;
        c_mult[0] = b_ext;
        if (r_state == S_RED_ISSUE) begin
            c_ctl[0]  = '{valid: 1'b1, tag: mexp_pkg::TAG_BAS};
            c_a[0]    = MOD_BITS'(1);
            c_mult[0] = r_base_in;
        end else if (r_state == S_ISSUE) begin
            if (r_exp[0] && !r_mul_sent) begin
                c_ctl[0] = '{valid: 1'b1, tag: mexp_pkg::TAG_ACC};
                c_a[0]   = r_acc;
            end else begin
                c_ctl[0] = '{valid: 1'b1, tag: mexp_pkg::TAG_BAS};
            end
        end
    end

    for (genvar g = 0; g < MW; g++) begin : g_cell
        mexp_cell #(.MOD_BITS(MOD_BITS)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (c_ctl[g]),
            .i_r    (c_r[g]),
            .i_a    (c_a[g]),
            .i_mult (c_mult[g]),
            .i_m    (c_m[g]),
            .o_ctl  (c_ctl[g+1]),
            .o_r    (c_r[g+1]),
            .o_a    (c_a[g+1]),
            .o_mult (c_mult[g+1]),
            .o_m    (c_m[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mod       <= mexp_pkg::MOD_RESET[MOD_BITS-1:0];
            r_out_valid <= 1'b0;
            r_mul_sent  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mod <= i_cfg_modulus;
            end
            // a finishing item reloads the output register itself
            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_base_in  <= i_base_value;
                        r_exp      <= exp_ext[EXP_BITS-1:0];
                        r_cnt      <= '0;
                        r_mul_sent <= 1'b0;
                        if (r_mod == '0) begin
                            r_acc   <= '0;
                            r_state <= S_FIN;
                        end else begin
                            r_acc   <= (r_mod == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                            r_state <= S_RED_ISSUE;
                        end
                    end
                end
                S_RED_ISSUE: r_state <= S_RED_WAIT;
                S_RED_WAIT: begin
                    if (c_ctl[MW].valid) begin
                        r_b     <= c_r[MW];
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (r_exp[0] && !r_mul_sent) begin
                        r_mul_sent <= 1'b1;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (c_ctl[MW].valid) begin
                        if (c_ctl[MW].tag == mexp_pkg::TAG_ACC) begin
                            r_acc <= c_r[MW];
                        end else begin
                            // square lands last; step to the next exponent bit
                            r_b        <= c_r[MW];
                            r_exp      <= r_exp >> 1;
                            r_cnt      <= r_cnt + CW'(1);
                            r_mul_sent <= 1'b0;
                            r_state    <= (r_cnt == LAST) ? S_FIN : S_ISSUE;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= 31'(r_acc);
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_power_result = r_out;

    `CHK_RST(a_chain_busy, i_clk, i_rst_n, c_ctl[MW].valid |-> (r_state == S_RED_WAIT || r_state == S_WAIT), "chain beat outside a wait state")
    `CHK_RST(a_take_one, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "input taken twice")
    `CHK_RST(a_res_range, i_clk, i_rst_n, (o_out_valid && r_mod != '0) |-> (32'(o_power_result) < 32'(r_mod)), "result not reduced")
    `CHK_ALL(a_rst_quiet, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")
endmodule

FILE: design/mexp_cell.sv
// One cell of the interleaved modular multiplier chain: one multiplier bit per cell.
`timescale 1ns / 1ps
module mexp_cell #(
    parameter int MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mexp_pkg::t_ctl          i_ctl,
    input  logic [MOD_BITS-1:0]     i_r,
    input  logic [MOD_BITS-1:0]     i_a,
    input  logic [mexp_pkg::MUL_W-1:0] i_mult,
    input  logic [MOD_BITS-1:0]     i_m,
    output mexp_pkg::t_ctl          o_ctl,
    output logic [MOD_BITS-1:0]     o_r,
    output logic [MOD_BITS-1:0]     o_a,
    output logic [mexp_pkg::MUL_W-1:0] o_mult,
    output logic [MOD_BITS-1:0]     o_m
);
    localparam int TW = MOD_BITS + 2;

    mexp_pkg::t_ctl              r_ctl;
    logic [MOD_BITS-1:0]         r_r, r_a, r_m;
    logic [mexp_pkg::MUL_W-1:0]  r_mult;
    logic [TW-1:0]               t0, t1, t2, m_ext;
    logic [MOD_BITS-1:0]         n_r;

    // r' = 2r + bit*a, below 3m, brought under m with two trial subtracts
    always_comb begin
        m_ext = {2'b00, i_m};
        t0 = {1'b0, i_r, 1'b0} + (i_mult[mexp_pkg::MUL_W-1] ? {2'b00, i_a} : '0);
        t1 = (t0 >= m_ext) ? t0 - m_ext : t0;
        t2 = (t1 >= m_ext) ? t1 - m_ext : t1;
        n_r = t2[MOD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_r    <= n_r;
        r_a    <= i_a;
        r_m    <= i_m;
        r_mult <= {i_mult[mexp_pkg::MUL_W-2:0], 1'b0};
    end

    assign o_ctl  = r_ctl;
    assign o_r    = r_r;
    assign o_a    = r_a;
    assign o_m    = r_m;
    assign o_mult = r_mult;
endmodule

FILE: tb/sv/modexp_checker.sv
// Checker for the modular exponentiation core: tracks the modulus, predicts and compares results.
`timescale 1ns / 1ps
module modexp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [30:0] i_cfg_modulus,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_base_value,
    input  logic [31:0] i_exponent,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [30:0] i_power_result,
    output int          o_errors,
    output int          o_pending
);
    logic [30:0] modulus_q = 31'd1000000007;
    logic [30:0] power_q[$];
    int          err_cnt = 0;

    // right-to-left square-and-multiply; operands stay below 2^31
    function automatic logic [30:0] modpow(logic [30:0] m, logic [31:0] b, logic [31:0] e);
        logic [63:0] acc;
        logic [63:0] sq;
        if (m == '0) return '0;
        sq  = 64'(b) % 64'(m);
        acc = 64'd1 % 64'(m);
        for (int i = 0; i < 32; i++) begin
            if (e[i]) acc = (acc * sq) % 64'(m);
            sq = (sq * sq) % 64'(m);
        end
        return acc[30:0];
    endfunction

    assign o_errors  = err_cnt;
    assign o_pending = power_q.size();

    always @(posedge i_clk) begin
        logic [30:0] want;
        if (!i_rst_n) begin
            modulus_q <= 31'd1000000007;
            power_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) modulus_q <= i_cfg_modulus;
            if (i_in_valid && i_in_ready)
                power_q.push_back(modpow(modulus_q, i_base_value, i_exponent));
            if (i_out_valid && i_out_ready) begin
                if (power_q.size() == 0) begin
                    $display("%0t: unexpected beat, power_result expected none, got %0d",
                             $time, i_power_result);
                    err_cnt++;
                end else begin
                    want = power_q.pop_front();
                    if (want !== i_power_result) begin
                        $display("%0t: power_result expected %0d, got %0d",
                                 $time, want, i_power_result);
                        err_cnt++;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/sv/modular_exponentiation_core_tb.sv
// Top of the modular exponentiation testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module modular_exponentiation_core_tb;
    localparam int WDOG_LIMIT = 40000;
    localparam int HOLD_CYCLES = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [30:0] i_cfg_modulus = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_base_value = '0;
    logic [31:0] i_exponent = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [30:0] o_power_result;

    int          errors;
    int          pending;
    int          in_idle_pct = 0;
    int          out_idle_pct = 0;
    bit          hold_req = 1'b0;
    bit          hold_seen = 1'b0;
    int          hold_cnt = 0;
    int          quiet_cycles = 0;
    logic [30:0] cur_mod = 31'd1000000007;

    modular_exponentiation_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_modulus(i_cfg_modulus),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_base_value(i_base_value), .i_exponent(i_exponent),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_power_result(o_power_result)
    );

    modexp_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_modulus(i_cfg_modulus),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_base_value(i_base_value), .i_exponent(i_exponent),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_power_result(o_power_result),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            hold_cnt  = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // returns at the edge that accepts the beat; ready is sampled mid-cycle
    task automatic send_item(logic [31:0] b, logic [31:0] e);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_base_value <= b;
        i_exponent   <= e;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
    endtask

    // waits until the block is idle
    task automatic write_modulus(logic [30:0] m);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid   <= 1'b1;
        i_cfg_modulus <= m;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_mod = m;
    endtask

    task automatic send_random(int n);
        logic [31:0] b;
        logic [31:0] e;
        for (int k = 0; k < n; k++) begin
            b = $urandom();
            case ($urandom_range(9))
                0: b = 32'h0;
                1: b = 32'hFFFF_FFFF;
                2: b = 32'(cur_mod) * $urandom_range(2);
                default: ;
            endcase
            case ($urandom_range(9))
                0: e = 32'(cur_mod) - 32'd2;   // Fermat inverse
                1: e = $urandom_range(8);
                2: e = 32'hFFFF_FFFF;
                default: e = $urandom();
            endcase
            send_item(b, e);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset modulus
        send_item(32'h0, 32'h0);
        send_item(32'h0, 32'h5);
        send_item(32'd7, 32'h0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'h1);
        send_item(32'd2, 32'd1000000005);
        send_item(32'd1000000006, 32'd1000000005);
        send_item(32'd1000000007, 32'd3);
        send_item(32'd1000000008, 32'h8000_0000);
        send_item(32'd123456789, 32'hAAAA_AAAA);
        send_item(32'd987654321, 32'h5555_5555);
        send_item(32'd3, 32'd2);
        write_modulus(31'd0);
        send_item(32'd5, 32'd3);
        send_item(32'hFFFF_FFFF, 32'h0);
        write_modulus(31'd1);
        send_item(32'd5, 32'd3);
        send_item(32'h0, 32'h0);
        write_modulus(31'd2);
        send_item(32'd3, 32'd0);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_modulus(31'h7FFF_FFFF);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'h7FFF_FFFE, 32'h7FFF_FFFD);
        send_random(20);

        in_idle_pct  = 38;
        out_idle_pct = 67;
        write_modulus(31'($urandom_range(2147483647, 2)));
        send_random(250);
        hold_req = 1'b1;
        send_random(250);

        in_idle_pct  = 67;
        out_idle_pct = 38;
        write_modulus(31'd1000000007);
        send_random(400);
        write_modulus(31'($urandom_range(1000, 2)));
        send_random(150);

        in_idle_pct  = 0;
        out_idle_pct = 0;
        write_modulus(31'($urandom_range(2147483647, 2)));
        send_random(500);
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (1200) @(posedge i_clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
